// ===== rtl/core/hdrm_pkg.sv =====
// Package for the Hamming descriptor ratio matcher.
// Holds table sizing, field widths, register indexes, reset values and the
// controller to datapath command and status types. Depends on nothing.
package hdrm_pkg;

  localparam int MAX_ENTRIES     = 256;
  localparam int WORDS_PER_DESC  = 4;
  localparam int WORD_W          = 64;
  localparam int DESC_W          = WORDS_PER_DESC * WORD_W;
  localparam int IDX_W           = $clog2(MAX_ENTRIES);
  localparam int CNT_W           = $clog2(MAX_ENTRIES + 1);

  localparam int ENTRY_W         = 8;
  localparam int DIST_W          = 9;
  localparam int RATIO_W         = 8;
  localparam int PROD_W          = DIST_W + RATIO_W;
  localparam int CMP_W           = (CNT_W > DIST_W) ? CNT_W : DIST_W;

  localparam int CHUNK_W         = 8;
  localparam int CHUNKS_PER_WORD = WORD_W / CHUNK_W;
  localparam int NUM_CHUNKS      = DESC_W / CHUNK_W;
  localparam int CHUNK_CNT_W     = 4;
  localparam int WORD_CNT_W      = 7;

  localparam int CFG_IDX_W       = 8;
  localparam int CFG_DATA_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_NUM      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_DEN      = 8'd3;

  localparam logic [DIST_W-1:0]  RST_ENTRIES_IN_USE = 9'd0;
  localparam logic [DIST_W-1:0]  RST_MAX_DISTANCE   = 9'd60;
  localparam logic [RATIO_W-1:0] RST_RATIO_NUM      = 8'd17;
  localparam logic [RATIO_W-1:0] RST_RATIO_DEN      = 8'd20;

  localparam logic [DIST_W-1:0]  DIST_NONE = 9'd257;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             wr_en;
    logic             start;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_status_t;

endpackage

// ===== rtl/core/hdrm_req_if.sv =====
// Request channel interface: valid, ready and one load or query beat.
// Depends on hdrm_pkg for field widths.
interface hdrm_req_if import hdrm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [ENTRY_W-1:0]  entry_index;
  logic [WORD_W-1:0]   desc_word0;
  logic [WORD_W-1:0]   desc_word1;
  logic [WORD_W-1:0]   desc_word2;
  logic [WORD_W-1:0]   desc_word3;

  modport source (output valid, req_type, entry_index, desc_word0, desc_word1,
                  desc_word2, desc_word3, input ready);
  modport sink   (input valid, req_type, entry_index, desc_word0, desc_word1,
                  desc_word2, desc_word3, output ready);
endinterface

// ===== rtl/core/hdrm_rsp_if.sv =====
// Result channel interface: valid, ready and one match result beat.
// Depends on hdrm_pkg for field widths.
interface hdrm_rsp_if import hdrm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               matched;
  logic [ENTRY_W-1:0] best_index;
  logic [DIST_W-1:0]  best_distance;
  logic [DIST_W-1:0]  second_distance;

  modport source (output valid, matched, best_index, best_distance, second_distance,
                  input ready);
  modport sink   (input valid, matched, best_index, best_distance, second_distance,
                  output ready);
endinterface

// ===== rtl/core/hdrm_cfg_if.sv =====
// Configuration write channel interface: valid, ready, register index and data.
// Depends on hdrm_pkg for field widths.
interface hdrm_cfg_if import hdrm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/hamming_descriptor_ratio_match_core.sv =====
// Top level of the Hamming descriptor ratio matcher.
// Depends on hdrm_pkg, the three channel interfaces, hdrm_ctrl and hdrm_datapath.
//
// Usage. The in_ch channel takes one beat per request. A load beat (req_type
// low) writes its 256-bit descriptor into table entry entry_index in the cycle
// it is accepted; an index at or beyond the table size is dropped, and a load
// produces no result. A query beat (req_type high) scans entries 0 up to
// entries_in_use minus one, one entry read from the descriptor RAM per cycle,
// and returns one beat on out_ch with the best and second distances, the index
// of the best entry and the match flag.
// Timing. A query scans N entries, where N is entries_in_use clipped to the
// table size, through the single RAM read port, then drains the three stage
// popcount and compare pipeline and loads the result register. An empty table
// skips the scan and goes straight to the result load. Requests are taken one
// at a time.
// Stalls. The result sits in an output register; while out_ch is stalled, the
// block still accepts loads and the next query, which waits at its end until
// the register is free. The cfg_ch port is always ready.
// Reset. rst_n is synchronous and active low; it restores the register reset
// values and empties the pipeline. Table contents are undefined until loaded.
module hamming_descriptor_ratio_match_core import hdrm_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  hdrm_req_if.sink  in_ch,
  hdrm_rsp_if.source out_ch,
  hdrm_cfg_if.sink  cfg_ch
);

  // Configuration registers.
  logic [DIST_W-1:0]  entries_in_use_r;
  logic [DIST_W-1:0]  max_distance_r;
  logic [RATIO_W-1:0] ratio_num_r;
  logic [RATIO_W-1:0] ratio_den_r;

  logic [CNT_W-1:0]   scan_count;
  logic               load_ok;
  logic [DESC_W-1:0]  in_desc;
  dp_cmd_t            cmd;
  dp_status_t         status;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= RST_ENTRIES_IN_USE;
      max_distance_r   <= RST_MAX_DISTANCE;
      ratio_num_r      <= RST_RATIO_NUM;
      ratio_den_r      <= RST_RATIO_DEN;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_ENTRIES_IN_USE: entries_in_use_r <= cfg_ch.data[DIST_W-1:0];
        CFG_MAX_DISTANCE:   max_distance_r   <= cfg_ch.data[DIST_W-1:0];
        CFG_RATIO_NUM:      ratio_num_r      <= cfg_ch.data[RATIO_W-1:0];
        CFG_RATIO_DEN:      ratio_den_r      <= cfg_ch.data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // A scan count above the table size is clipped to the table size.
  always_comb begin
    if (CMP_W'(entries_in_use_r) > CMP_W'(MAX_ENTRIES)) begin
      scan_count = CNT_W'(MAX_ENTRIES);
    end else begin
      scan_count = CNT_W'(entries_in_use_r);
    end
  end

  assign load_ok = (32'(in_ch.entry_index) < MAX_ENTRIES);
  assign in_desc = {in_ch.desc_word3, in_ch.desc_word2, in_ch.desc_word1, in_ch.desc_word0};

  hdrm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req_type (in_ch.req_type),
    .in_load_ok  (load_ok),
    .scan_count  (scan_count),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cmd         (cmd),
    .status      (status)
  );

  hdrm_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_desc             (in_desc),
    .wr_addr             (IDX_W'(in_ch.entry_index)),
    .max_distance        (max_distance_r),
    .ratio_num           (ratio_num_r),
    .ratio_den           (ratio_den_r),
    .out_matched         (out_ch.matched),
    .out_best_index      (out_ch.best_index),
    .out_best_distance   (out_ch.best_distance),
    .out_second_distance (out_ch.second_distance)
  );

endmodule

// ===== rtl/core/hdrm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Self-contained; no package dependency.
module hdrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/hdrm_datapath.sv =====
// Matcher datapath: descriptor RAM, pipelined Hamming distance, best and second
// tracking, ratio test and result register. Depends on hdrm_pkg and hdrm_ram.
module hdrm_datapath import hdrm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic [DESC_W-1:0]  in_desc,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [DIST_W-1:0]  max_distance,
  input  logic [RATIO_W-1:0] ratio_num,
  input  logic [RATIO_W-1:0] ratio_den,
  output logic               out_matched,
  output logic [ENTRY_W-1:0] out_best_index,
  output logic [DIST_W-1:0]  out_best_distance,
  output logic [DIST_W-1:0]  out_second_distance
);

  function automatic logic [CHUNK_CNT_W-1:0] pop_chunk(input logic [CHUNK_W-1:0] b);
    logic [CHUNK_CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      n = n + CHUNK_CNT_W'(b[i]);
    end
    return n;
  endfunction

  logic [DESC_W-1:0]      query_r;
  logic [DESC_W-1:0]      rd_data;

  // Pipeline: RAM read, chunk counts, word sums, compare and update.
  logic                   v0_r, v1_r, v2_r;
  logic [IDX_W-1:0]       idx0_r, idx1_r, idx2_r;
  logic [CHUNK_CNT_W-1:0] chunk_r [NUM_CHUNKS];
  logic [WORD_CNT_W-1:0]  word_r  [WORDS_PER_DESC];

  logic [DIST_W-1:0]      best_r, best_nxt;
  logic [DIST_W-1:0]      second_r, second_nxt;
  logic [IDX_W-1:0]       best_at_r, best_at_nxt;
  logic [DIST_W-1:0]      ham_dist;

  logic                   matched_r;
  logic [ENTRY_W-1:0]     best_index_r;
  logic [DIST_W-1:0]      best_distance_r;
  logic [DIST_W-1:0]      second_distance_r;

  logic [PROD_W-1:0]      lhs, rhs;
  logic                   matched_nxt;
  logic [DESC_W-1:0]      diff;

  hdrm_ram #(
    .WIDTH (DESC_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (in_desc),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (rd_data)
  );

  assign diff = rd_data ^ query_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= cmd.rd_en;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      query_r <= in_desc;
    end
    idx0_r <= cmd.rd_addr;
    idx1_r <= idx0_r;
    idx2_r <= idx1_r;
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      chunk_r[c] <= pop_chunk(diff[c*CHUNK_W +: CHUNK_W]);
    end
    for (int w = 0; w < WORDS_PER_DESC; w++) begin
      logic [WORD_CNT_W-1:0] s;
      s = '0;
      for (int c = 0; c < CHUNKS_PER_WORD; c++) begin
        s = s + WORD_CNT_W'(chunk_r[w*CHUNKS_PER_WORD + c]);
      end
      word_r[w] <= s;
    end
  end

  always_comb begin
    ham_dist = '0;
    for (int w = 0; w < WORDS_PER_DESC; w++) begin
      ham_dist = ham_dist + DIST_W'(word_r[w]);
    end
  end

  // A tie with the best leaves the index alone and pulls the second down.
  always_comb begin
    best_nxt    = best_r;
    second_nxt  = second_r;
    best_at_nxt = best_at_r;
    if (cmd.start) begin
      best_nxt    = DIST_NONE;
      second_nxt  = DIST_NONE;
      best_at_nxt = '0;
    end else if (v2_r) begin
      if (ham_dist < best_r) begin
        second_nxt  = best_r;
        best_nxt    = ham_dist;
        best_at_nxt = idx2_r;
      end else if (ham_dist < second_r) begin
        second_nxt = ham_dist;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_r    <= best_nxt;
    second_r  <= second_nxt;
    best_at_r <= best_at_nxt;
  end

  assign lhs = PROD_W'(best_r) * PROD_W'(ratio_den);
  assign rhs = PROD_W'(second_r) * PROD_W'(ratio_num);
  assign matched_nxt = (best_r <= max_distance) && (lhs <= rhs);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      matched_r         <= matched_nxt;
      best_index_r      <= ENTRY_W'(best_at_r);
      best_distance_r   <= best_r;
      second_distance_r <= second_r;
    end
  end

  assign status.pipe_busy    = v0_r | v1_r | v2_r;
  assign out_matched         = matched_r;
  assign out_best_index      = best_index_r;
  assign out_best_distance   = best_distance_r;
  assign out_second_distance = second_distance_r;

endmodule

// ===== rtl/core/hdrm_ctrl.sv =====
// Matcher controller: request handshake, scan sequencing and result valid.
// Depends on hdrm_pkg; drives hdrm_datapath through dp_cmd_t.
module hdrm_ctrl import hdrm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_req_type,
  input  logic             in_load_ok,
  input  logic [CNT_W-1:0] scan_count,
  output logic             out_valid,
  input  logic             out_ready,
  output dp_cmd_t          cmd,
  input  dp_status_t       status
);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      count_r     <= count_nxt;
    end
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    count_nxt    = count_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.rd_addr  = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (in_req_type == REQ_QUERY) begin
            cmd.start = 1'b1;
            count_nxt = scan_count;
            cnt_nxt   = '0;
            state_nxt = (scan_count == '0) ? ST_DONE : ST_SCAN;
          end else begin
            cmd.wr_en = in_load_ok;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (CNT_W'(cnt_r) == count_r - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register loaded over an untaken beat");

  a_valid_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result valid missing after load");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (CNT_W'(cnt_r) < count_r))
    else $error("scan address beyond entries in use");

  a_done_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> !status.pipe_busy)
    else $error("result taken while distances still in flight");

endmodule
